### hdl/ocu_pkg.sv
// shared types, constants and table functions of the orbit camera update block
`default_nettype none

package ocu_pkg;

  localparam int AMT_W   = 16;
  localparam int PITCH_W = 13;
  localparam int ANGLE_W = 15;
  localparam int POS_W   = 24;
  localparam int TRIG_W  = 16;
  localparam int RAD_W   = 12;
  localparam int HGT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int FULL_TURN   = 23040;
  localparam int RIGHT_ANGLE = 5760;
  localparam int PITCH_RESET = 1920;
  localparam int RADIUS_RESET = 100;
  localparam int HEIGHT_RESET = 80;

  // 23040 = 512 * 45, angle index split into a shift and a small reciprocal
  localparam int ANGLE_PRESHIFT = 9;
  localparam int ANGLE_ODD_DIV  = 45;

  localparam logic [0:0] KIND_ROTATE = 1'b0;
  localparam logic [0:0] KIND_MOVE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd1;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

  typedef struct packed {
    logic [0:0]                kind;
    logic signed [AMT_W-1:0]   first_amount;
    logic signed [AMT_W-1:0]   second_amount;
    logic [PITCH_W-1:0]        pitch;
    logic [ANGLE_W-1:0]        yaw;
  } cmd_t;

  typedef struct packed {
    logic [RAD_W-1:0]          orbit_radius;
    logic signed [HGT_W-1:0]   target_height;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   eye_x;
    logic signed [POS_W-1:0]   eye_y;
    logic signed [POS_W-1:0]   eye_z;
    logic signed [POS_W-1:0]   look_x;
    logic signed [POS_W-1:0]   look_y;
    logic signed [POS_W-1:0]   look_z;
    logic signed [TRIG_W-1:0]  up_x;
    logic signed [TRIG_W-1:0]  up_y;
    logic signed [TRIG_W-1:0]  up_z;
  } result_t;

  // q1.15 sine of a 32 bit phase, evaluated only when the table is built
  function automatic logic signed [TRIG_W-1:0] sin_phase(input logic [31:0] p);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint v;
    r = {34'd0, p[29:0]};
    if (p[30]) begin
      r = 64'h4000_0000 - r;
    end
    x = (r * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return p[31] ? TRIG_W'(-v) : TRIG_W'(v);
  endfunction

  // {cosine, sine} for one table phase
  function automatic logic [2*TRIG_W-1:0] trig_pair(input logic [31:0] ph);
    return {sin_phase(ph + 32'h4000_0000), sin_phase(ph)};
  endfunction

endpackage

`default_nettype wire

### hdl/ocu_front.sv
// front end: takes input beats, updates the angles on rotate and queues a command
`default_nettype none

module ocu_front
  import ocu_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [0:0]              kind,
  input  wire logic signed [AMT_W-1:0] first_amount,
  input  wire logic signed [AMT_W-1:0] second_amount,
  output logic                         cmd_valid,
  input  wire logic                    cmd_ready,
  output cmd_t                         cmd
);

  logic [PITCH_W-1:0] pitch;
  logic [ANGLE_W-1:0] yaw;
  logic [PITCH_W-1:0] pitch_next;
  logic [ANGLE_W-1:0] yaw_next;
  logic signed [17:0] pitch_sum;
  logic signed [17:0] yaw_sum;
  logic signed [AMT_W-1:0] yaw_delta;
  logic accept;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  always_comb begin
    pitch_sum = 18'(signed'({1'b0, pitch})) + 18'(first_amount);
    if (pitch_sum > 18'sd5760) begin
      pitch_next = PITCH_W'(RIGHT_ANGLE);
    end else if (pitch_sum < 18'sd0) begin
      pitch_next = '0;
    end else begin
      pitch_next = pitch_sum[PITCH_W-1:0];
    end

    if (second_amount > 16'sd23040) begin
      yaw_delta = 16'sd23040;
    end else if (second_amount < -16'sd23040) begin
      yaw_delta = -16'sd23040;
    end else begin
      yaw_delta = second_amount;
    end
    yaw_sum = 18'(signed'({1'b0, yaw})) + 18'(yaw_delta);
    // wrap once; an exact zero lands on a full turn
    if (yaw_sum >= 18'sd23040) begin
      yaw_next = ANGLE_W'(yaw_sum - 18'sd23040);
    end else if (yaw_sum <= 18'sd0) begin
      yaw_next = ANGLE_W'(yaw_sum + 18'sd23040);
    end else begin
      yaw_next = yaw_sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    cmd.kind          = kind;
    cmd.first_amount  = first_amount;
    cmd.second_amount = second_amount;
    if (kind == KIND_ROTATE) begin
      cmd.pitch = pitch_next;
      cmd.yaw   = yaw_next;
    end else begin
      cmd.pitch = pitch;
      cmd.yaw   = yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= PITCH_W'(PITCH_RESET);
      yaw   <= '0;
    end else if (accept && kind == KIND_ROTATE) begin
      pitch <= pitch_next;
      yaw   <= yaw_next;
    end
  end

endmodule

`default_nettype wire

### hdl/ocu_queue.sv
// short command queue between the front end and the back end
`default_nettype none

module ocu_queue
  import ocu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      out_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic push;
  logic pop;

  assign in_ready  = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ocu_trig.sv
// pipelined angle to sine and cosine lookup: index by reciprocal, then table read
`default_nettype none

module ocu_trig
  import ocu_pkg::*;
#(
  parameter int TRIG_TABLE_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [ANGLE_W-1:0]   angle,
  output logic                      out_valid,
  output logic signed [TRIG_W-1:0]  sin_val,
  output logic signed [TRIG_W-1:0]  cos_val
);

  localparam int QW    = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH);
  localparam int NW    = ANGLE_W + QW;
  localparam int MW    = NW - ANGLE_PRESHIFT;
  localparam int K     = MW + 6;
  localparam logic [K:0] RECIP =
    (K+1)'(((64'd1 << K) + ANGLE_ODD_DIV - 1) / ANGLE_ODD_DIV);

  logic [2*TRIG_W-1:0] rom [TRIG_TABLE_DEPTH];

  for (genvar g = 0; g < TRIG_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned PH = (64'(g) << 32) / TRIG_TABLE_DEPTH;
    assign rom[g] = trig_pair(32'(PH));
  end

  logic [3:0]          vld;
  logic [NW-1:0]       scaled;
  logic [MW-1:0]       coarse;
  logic [MW+K:0]       recip_prod;
  logic [QW-1:0]       quot;
  logic [IDX_W-1:0]    idx;
  logic [2*TRIG_W-1:0] rom_q;

  assign scaled     = NW'(angle) * NW'(TRIG_TABLE_DEPTH);
  assign recip_prod = (MW+K+1)'(coarse) * (MW+K+1)'(RECIP);

  always_ff @(posedge clk) begin
    coarse <= scaled[NW-1:ANGLE_PRESHIFT];
    quot   <= recip_prod[K +: QW];
    // a full turn folds back to entry zero
    idx    <= (quot == QW'(TRIG_TABLE_DEPTH)) ? '0 : quot[IDX_W-1:0];
    rom_q  <= rom[idx];
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];
  assign sin_val   = signed'(rom_q[TRIG_W-1:0]);
  assign cos_val   = signed'(rom_q[2*TRIG_W-1:TRIG_W]);

endmodule

`default_nettype wire

### hdl/ocu_back.sv
// back end: sequences the shared multiplier over target move, eye position and up vector
`default_nettype none

module ocu_back
  import ocu_pkg::*;
#(
  parameter int TRIG_TABLE_DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd_in,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);

  localparam int MB_W = 22;
  localparam int PR_W = TRIG_W + MB_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PITCH, ST_WAIT, ST_MOVE, ST_SUM, ST_TGT, ST_COMMON, ST_DRAIN, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_XA, OP_XB, OP_ZA, OP_ZB, OP_EY, OP_CXZ, OP_EX, OP_EZ, OP_UX, OP_UZ
  } op_t;

  state_t state;
  op_t    issue_op;
  op_t    prod_op;
  logic [2:0] step;
  cmd_t   cmd;
  logic   got_yaw;

  logic                  trig_in_valid;
  logic [ANGLE_W-1:0]    trig_angle;
  logic                  trig_valid;
  logic signed [TRIG_W-1:0] trig_sin;
  logic signed [TRIG_W-1:0] trig_cos;

  logic signed [TRIG_W-1:0] sy, cy, sp, cp;
  logic signed [TRIG_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PR_W-1:0]   mult_res;
  logic signed [PR_W-1:0]   prod;
  logic signed [PR_W-1:0]   acc;
  logic signed [PR_W-1:0]   sum_x;
  logic signed [PR_W-1:0]   sum_z;
  logic signed [MB_W-1:0]   cxz;
  logic signed [POS_W-1:0]  tx;
  logic signed [POS_W-1:0]  tz;
  logic signed [16:0]       neg_first;
  logic signed [16:0]       neg_second;
  logic signed [MB_W-1:0]   r256;
  logic signed [POS_W-1:0]  ty256;
  logic signed [POS_W-1:0]  eye_x;
  logic signed [POS_W-1:0]  eye_y;
  logic signed [POS_W-1:0]  eye_z;
  logic signed [TRIG_W-1:0] up_x;
  logic signed [TRIG_W-1:0] up_z;

  ocu_trig #(
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
  ) u_trig (
    .clk      (clk),
    .rst      (rst),
    .in_valid (trig_in_valid),
    .angle    (trig_angle),
    .out_valid(trig_valid),
    .sin_val  (trig_sin),
    .cos_val  (trig_cos)
  );

  function automatic logic signed [22:0] rshr15(input logic signed [PR_W-1:0] v);
    logic signed [PR_W-1:0] w;
    w = v + PR_W'(16384);
    return 23'(w >>> 15);
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [POS_W:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      return 24'sh800000;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [TRIG_W-1:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[TRIG_W-1:0];
  endfunction

  assign neg_first  = -17'(cmd.first_amount);
  assign neg_second = -17'(cmd.second_amount);
  assign r256       = signed'({2'b00, cfg.orbit_radius, 8'd0});
  assign ty256      = signed'({cfg.target_height, 8'd0});
  assign mult_res   = mul_a * mul_b;
  assign cmd_ready  = state == ST_IDLE;

  always_comb begin
    trig_in_valid = 1'b0;
    trig_angle    = cmd_in.yaw;
    issue_op      = OP_NONE;
    mul_a         = sy;
    mul_b         = cxz;
    unique case (state)
      ST_IDLE: begin
        trig_in_valid = cmd_valid;
      end
      ST_PITCH: begin
        trig_in_valid = 1'b1;
        trig_angle    = ANGLE_W'(cmd.pitch);
      end
      ST_MOVE: begin
        case (step)
          3'd0: begin
            issue_op = OP_XA; mul_a = sy; mul_b = MB_W'(neg_first);
          end
          3'd1: begin
            issue_op = OP_XB; mul_a = cy; mul_b = MB_W'(neg_second);
          end
          3'd2: begin
            issue_op = OP_ZA; mul_a = cy; mul_b = MB_W'(neg_first);
          end
          default: begin
            issue_op = OP_ZB; mul_a = sy; mul_b = MB_W'(cmd.second_amount);
          end
        endcase
      end
      ST_COMMON: begin
        // horizontal radius first so it is registered before its two users
        case (step)
          3'd0: begin
            issue_op = OP_CXZ; mul_a = cp; mul_b = r256;
          end
          3'd1: begin
            issue_op = OP_EY; mul_a = sp; mul_b = r256;
          end
          3'd2: begin
            issue_op = OP_EX; mul_a = sy; mul_b = cxz;
          end
          3'd3: begin
            issue_op = OP_EZ; mul_a = cy; mul_b = cxz;
          end
          3'd4: begin
            issue_op = OP_UX; mul_a = sp; mul_b = MB_W'(sy);
          end
          default: begin
            issue_op = OP_UZ; mul_a = sp; mul_b = MB_W'(cy);
          end
        endcase
      end
      ST_WAIT, ST_SUM, ST_TGT, ST_DRAIN, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mult_res;

    case (prod_op)
      OP_XA: acc <= prod;
      OP_XB: sum_x <= acc + prod;
      OP_ZA: acc <= prod;
      OP_ZB: sum_z <= acc + prod;
      OP_CXZ: cxz <= MB_W'(rshr15(prod));
      OP_EY: eye_y <= sat24(25'(rshr15(prod)) + 25'(ty256));
      OP_EX: eye_x <= sat24(25'(rshr15(prod)) + 25'(tx));
      OP_EZ: eye_z <= sat24(25'(rshr15(prod)) + 25'(tz));
      OP_UX: up_x <= sat16(-24'(rshr15(prod)));
      OP_UZ: up_z <= sat16(-24'(rshr15(prod)));
      default: begin
      end
    endcase

    if (trig_valid) begin
      if (!got_yaw) begin
        sy <= trig_sin;
        cy <= trig_cos;
      end else begin
        sp <= trig_sin;
        cp <= trig_cos;
      end
    end

    if (state == ST_IDLE && cmd_valid) begin
      cmd <= cmd_in;
    end

    if (state == ST_OUT && (!res_valid || res_ready)) begin
      res <= {eye_x, eye_y, eye_z, tx, ty256, tz, up_x, cp, up_z};
    end

    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      prod_op   <= OP_NONE;
      got_yaw   <= 1'b0;
      res_valid <= 1'b0;
      tx        <= '0;
      tz        <= '0;
    end else begin
      prod_op <= issue_op;
      if (trig_valid) begin
        got_yaw <= !got_yaw;
      end
      // a new beat loaded in the same cycle keeps valid high
      if (res_valid && res_ready && state != ST_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= ST_PITCH;
          end
        end
        ST_PITCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          // pitch result lands on the beat after the yaw result
          if (trig_valid && got_yaw) begin
            step  <= '0;
            state <= (cmd.kind == KIND_MOVE) ? ST_MOVE : ST_COMMON;
          end
        end
        ST_MOVE: begin
          if (step == 3'd3) begin
            state <= ST_SUM;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SUM: begin
          state <= ST_TGT;
        end
        ST_TGT: begin
          tx    <= sat24(25'(rshr15(sum_x)) + 25'(tx));
          tz    <= sat24(25'(rshr15(sum_z)) + 25'(tz));
          step  <= '0;
          state <= ST_COMMON;
        end
        ST_COMMON: begin
          if (step == 3'd5) begin
            state <= ST_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/orbit_camera_update.sv
// top level of the orbit camera update block
`default_nettype none

// Orbit camera controller. Each input beat either rotates the camera (pitch and
// yaw deltas in 1/64 degree, pitch clamped to 0..90 degrees, yaw wrapped to
// 0..360) or moves the ground-plane target along the yaw heading (Q8.8 steps).
// Every input beat gives one output beat with the eye position, the target and
// the up vector. The front end updates the angles and queues up to two commands,
// so input beats are taken while the back end works. The back end runs one
// command at a time: a sine/cosine lookup done once for yaw and once for pitch,
// followed by one pass of a single shared 16 x 22 bit multiplier (six products
// for every item, four more to move the target). Configuration writes are
// always taken.
module orbit_camera_update
  import ocu_pkg::*;
#(
  parameter int TRIG_TABLE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,   // first_amount, second_amount
  input  wire logic [0:0]            s_tuser,   // kind
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [191:0]               m_tdata,   // eye_x, eye_y, eye_z, look_x,
                                                // look_y, look_z, up_x, up_y, up_z
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  cmd_t    front_cmd;
  cmd_t    queue_cmd;
  logic    front_valid;
  logic    front_ready;
  logic    queue_valid;
  logic    queue_ready;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orbit_radius  <= RAD_W'(RADIUS_RESET);
      cfg.target_height <= HGT_W'(HEIGHT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORBIT_RADIUS:  cfg.orbit_radius  <= cfg_data[RAD_W-1:0];
        REG_TARGET_HEIGHT: cfg.target_height <= signed'(cfg_data[HGT_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  ocu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .kind         (s_tuser),
    .first_amount (signed'(s_tdata[15:0])),
    .second_amount(signed'(s_tdata[31:16])),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready),
    .cmd          (front_cmd)
  );

  ocu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_cmd   (front_cmd),
    .out_valid(queue_valid),
    .out_ready(queue_ready),
    .out_cmd  (queue_cmd)
  );

  ocu_back #(
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(queue_valid),
    .cmd_ready(queue_ready),
    .cmd_in   (queue_cmd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {res.up_z, res.up_y, res.up_x, res.look_z, res.look_y, res.look_x,
                    res.eye_z, res.eye_y, res.eye_x};

endmodule

`default_nettype wire
